FILE: sv/htb_pkg.sv
package htb_pkg;

  // Default byte limit per text
  localparam int unsigned MAX_BYTES_DEF = 512;

  // Width of the reported byte count
  localparam int unsigned COUNT_W = 10;

  // Character codes used by the decoder
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_UP_A    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_F    = 8'h46;  // 'F'
  localparam logic [7:0] CH_LOW_A   = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOW_F   = 8'h66;  // 'f'
  localparam logic [7:0] CH_UP_X    = 8'h58;  // 'X'
  localparam logic [7:0] CH_LOW_X   = 8'h78;  // 'x'
  localparam logic [3:0] LETTER_OFS = 4'd10;

  // Character class of one input character
  typedef struct packed {
    logic       is_hex;
    logic       is_zero;
    logic       is_x;
    logic [3:0] value;
  } htb_dec_t;

  // One result beat, plus a flag saying whether the item emits it
  typedef struct packed {
    logic               emit;
    logic               data_valid;
    logic [7:0]         data_byte;
    logic               done_res;
    logic [COUNT_W-1:0] byte_count;
    logic               odd_digits;
  } htb_res_t;

endpackage

FILE: sv/htb_decode.sv
module htb_decode (
  input  logic [7:0]       ch,
  output htb_pkg::htb_dec_t dec
);

  logic is_digit;
  logic is_upper;
  logic is_lower;

  // Classify the character
  always_comb begin
    is_digit = (ch >= htb_pkg::CH_ZERO)  && (ch <= htb_pkg::CH_NINE);
    is_upper = (ch >= htb_pkg::CH_UP_A)  && (ch <= htb_pkg::CH_UP_F);
    is_lower = (ch >= htb_pkg::CH_LOW_A) && (ch <= htb_pkg::CH_LOW_F);

    dec.is_hex  = is_digit || is_upper || is_lower;
    dec.is_zero = (ch == htb_pkg::CH_ZERO);
    dec.is_x    = (ch == htb_pkg::CH_LOW_X) || (ch == htb_pkg::CH_UP_X);

    // Map to nibble value; letters add ten to their offset from 'a'/'A'
    if (is_digit) begin
      dec.value = ch[3:0];
    end else if (is_upper) begin
      dec.value = 4'((ch - htb_pkg::CH_UP_A)) + htb_pkg::LETTER_OFS;
    end else if (is_lower) begin
      dec.value = 4'((ch - htb_pkg::CH_LOW_A)) + htb_pkg::LETTER_OFS;
    end else begin
      dec.value = 4'h0;
    end
  end

endmodule

FILE: sv/htb_pack.sv
module htb_pack #(
  parameter int unsigned MAX_BYTES = htb_pkg::MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              eot,
  input  htb_pkg::htb_dec_t dec,
  output htb_pkg::htb_res_t res
);

  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);

  logic             zero_held;
  logic             nibble_held;
  logic [3:0]       high_nibble;
  logic [CNT_W-1:0] bytes_done;
  logic             limit_reached;

  logic             zero_held_next;
  logic             nibble_held_next;
  logic [3:0]       high_nibble_next;
  logic [CNT_W-1:0] bytes_done_next;
  logic             limit_reached_next;

  logic [CNT_W-1:0]                      cnt_inc;
  logic                                  at_limit;
  logic                                  dv;
  logic [7:0]                            byte_val;
  logic                                  odd;
  logic [CNT_W-1:0]                      count_sel;
  logic [CNT_W+htb_pkg::COUNT_W-1:0]     count_wide;

  assign cnt_inc  = bytes_done + CNT_W'(1);
  assign at_limit = (cnt_inc == CNT_W'(MAX_BYTES));

  // Step the packer for one item
  always_comb begin
    zero_held_next     = zero_held;
    nibble_held_next   = nibble_held;
    high_nibble_next   = high_nibble;
    limit_reached_next = limit_reached;
    dv                 = 1'b0;
    byte_val           = 8'h00;
    odd                = 1'b0;

    if (eot) begin
      // Flush a held zero as a digit
      if (zero_held && !limit_reached) begin
        if (nibble_held) begin
          byte_val         = {high_nibble, 4'h0};
          dv               = 1'b1;
          nibble_held_next = 1'b0;
        end else begin
          nibble_held_next = 1'b1;
          high_nibble_next = 4'h0;
        end
      end
      odd = nibble_held_next && !limit_reached;
    end else if (limit_reached) begin
      zero_held_next = 1'b0;
    end else if (!(zero_held && dec.is_x)) begin
      zero_held_next = 1'b0;
      // Held zero was a real digit
      if (zero_held) begin
        if (nibble_held) begin
          byte_val         = {high_nibble, 4'h0};
          dv               = 1'b1;
          nibble_held_next = 1'b0;
        end else begin
          nibble_held_next = 1'b1;
          high_nibble_next = 4'h0;
        end
      end
      // Take the new character unless the limit was just hit
      if (!(dv && at_limit)) begin
        if (dec.is_zero) begin
          zero_held_next = 1'b1;
        end else if (dec.is_hex) begin
          if (nibble_held_next) begin
            byte_val         = {high_nibble_next, dec.value};
            dv               = 1'b1;
            nibble_held_next = 1'b0;
          end else begin
            high_nibble_next = dec.value;
            nibble_held_next = 1'b1;
          end
        end
      end
    end else begin
      // Drop the "0x" prefix
      zero_held_next = 1'b0;
    end

    bytes_done_next = dv ? cnt_inc : bytes_done;
    if (dv && at_limit) begin
      limit_reached_next = 1'b1;
    end

    count_sel  = odd ? '0 : bytes_done_next;
    count_wide = {{htb_pkg::COUNT_W{1'b0}}, count_sel};

    res.emit       = dv || eot;
    res.data_valid = dv;
    res.data_byte  = byte_val;
    res.done_res   = eot;
    res.byte_count = eot ? count_wide[htb_pkg::COUNT_W-1:0] : '0;
    res.odd_digits = odd;
  end

  // Update state; end of text starts the next text fresh
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_held     <= 1'b0;
      nibble_held   <= 1'b0;
      high_nibble   <= 4'h0;
      bytes_done    <= '0;
      limit_reached <= 1'b0;
    end else if (step) begin
      if (eot) begin
        zero_held     <= 1'b0;
        nibble_held   <= 1'b0;
        high_nibble   <= 4'h0;
        bytes_done    <= '0;
        limit_reached <= 1'b0;
      end else begin
        zero_held     <= zero_held_next;
        nibble_held   <= nibble_held_next;
        high_nibble   <= high_nibble_next;
        bytes_done    <= bytes_done_next;
        limit_reached <= limit_reached_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_done <= CNT_W'(MAX_BYTES))
    else $error("byte count passed the limit");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    step && eot |=> !zero_held && !nibble_held && !limit_reached && (bytes_done == '0))
    else $error("state not cleared after end of text");

  a_limit_idle: assert property (@(posedge clk) disable iff (rst)
    limit_reached |-> (bytes_done == CNT_W'(MAX_BYTES)) && !nibble_held)
    else $error("limit flag out of step with count");
`endif

endmodule

FILE: sv/hex_text_to_bytes.sv
// Channel  Dir  Beat contents
// s_*      in   tdata[7:0] ch, tlast end_of_text
// m_*      out  tdata[7:0] data_byte, tdata[17:8] byte_count, tlast done_res,
//               tuser[0] data_valid, tuser[1] odd_digits
//
// One character per cycle while m_tready does not stall the output; a taken
// beat is held in the input register and its result in the output register.
// The input register, packer state and output register all advance together,
// so the combinational decode-and-pack path sets the rate.
// Characters that complete no byte produce no output beat, but end of text always produces the final beat.
// Synchronous reset clears the valid flags and packer state.
// A stall on m_tready holds the output and backs up into s_tready.
module hex_text_to_bytes #(
  parameter int unsigned MAX_BYTES = htb_pkg::MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [17:8] byte_count, [23:18] zero
  output logic [1:0]  m_tuser,   // [0] data_valid, [1] odd_digits
  output logic        m_tlast
);

  logic              in_valid;
  logic [7:0]        in_ch;
  logic              in_eot;
  logic              advance;
  logic              s_accept;
  htb_pkg::htb_dec_t dec;
  htb_pkg::htb_res_t res;

  logic                       out_valid;
  logic                       out_dv;
  logic [7:0]                 out_byte;
  logic                       out_done;
  logic [htb_pkg::COUNT_W-1:0] out_count;
  logic                       out_odd;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_accept || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_ch  <= s_tdata;
      in_eot <= s_tlast;
    end
  end

  htb_decode u_decode (
    .ch  (in_ch),
    .dec (dec)
  );

  htb_pack #(
    .MAX_BYTES (MAX_BYTES)
  ) u_pack (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .eot  (in_eot),
    .dec  (dec),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_dv    <= res.data_valid;
      out_byte  <= res.data_byte;
      out_done  <= res.done_res;
      out_count <= res.byte_count;
      out_odd   <= res.odd_digits;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_count, out_byte};
  assign m_tuser  = {out_odd, out_dv};
  assign m_tlast  = out_done;

`ifndef NO_ASSERTIONS
  a_beat_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[0] && (m_tdata[17:8] == '0) && !m_tuser[1])
    else $error("non-final beat without a byte");

  a_odd_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata[17:8] == '0))
    else $error("odd flag with nonzero count or off the final beat");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled without a full pipeline");
`endif

endmodule
